@@ src/pbu_pkg.sv @@
// ----------------------------------------------------------------------------
// pbu_pkg
// Shared types, register map, equation and factor codes, and helper
// functions for the pixel blend unit.
// ----------------------------------------------------------------------------
package pbu_pkg;

   // Input pixel pair: first field in the most significant byte
   typedef struct packed {
      logic [7:0] src_red;
      logic [7:0] src_green;
      logic [7:0] src_blue;
      logic [7:0] src_alpha;
      logic [7:0] dst_red;
      logic [7:0] dst_green;
      logic [7:0] dst_blue;
      logic [7:0] dst_alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_type;

   // Lane 0 red, 1 green, 2 blue, 3 alpha
   typedef logic [3:0][7:0]  quad_type;
   typedef logic [3:0][15:0] quad_wide_type;

   localparam int ALPHA_LANE = 3;

   // Register file contents
   typedef struct packed {
      logic [2:0] color_eq;
      logic [2:0] alpha_eq;
      logic [3:0] color_src_fac;
      logic [3:0] color_dst_fac;
      logic [3:0] alpha_src_fac;
      logic [3:0] alpha_dst_fac;
   } cfg_type;

   // Register indexes (byte address = 4 * index)
   localparam int          CSR_ADDR_W      = 5;
   localparam logic [2:0]  REG_COLOR_EQ    = 3'd0;
   localparam logic [2:0]  REG_ALPHA_EQ    = 3'd1;
   localparam logic [2:0]  REG_COLOR_SRC   = 3'd2;
   localparam logic [2:0]  REG_COLOR_DST   = 3'd3;
   localparam logic [2:0]  REG_ALPHA_SRC   = 3'd4;
   localparam logic [2:0]  REG_ALPHA_DST   = 3'd5;

   // Blend equations
   localparam logic [2:0]  EQ_ADD  = 3'd0;
   localparam logic [2:0]  EQ_SUB  = 3'd1;
   localparam logic [2:0]  EQ_RSUB = 3'd2;
   localparam logic [2:0]  EQ_MIN  = 3'd3;
   localparam logic [2:0]  EQ_MAX  = 3'd4;

   // Factor modes
   localparam logic [3:0]  FAC_ZERO          = 4'd0;
   localparam logic [3:0]  FAC_ONE           = 4'd1;
   localparam logic [3:0]  FAC_SRC           = 4'd2;
   localparam logic [3:0]  FAC_INV_SRC       = 4'd3;
   localparam logic [3:0]  FAC_DST           = 4'd4;
   localparam logic [3:0]  FAC_INV_DST       = 4'd5;
   localparam logic [3:0]  FAC_SRC_ALPHA     = 4'd6;
   localparam logic [3:0]  FAC_INV_SRC_ALPHA = 4'd7;
   localparam logic [3:0]  FAC_DST_ALPHA     = 4'd8;
   localparam logic [3:0]  FAC_INV_DST_ALPHA = 4'd9;
   localparam logic [3:0]  FAC_DA_INV_SA     = 4'd10;

   // Reset values of the registers
   localparam logic [2:0]  RST_COLOR_EQ  = EQ_ADD;
   localparam logic [2:0]  RST_ALPHA_EQ  = EQ_ADD;
   localparam logic [3:0]  RST_COLOR_SRC = FAC_SRC_ALPHA;
   localparam logic [3:0]  RST_COLOR_DST = FAC_INV_SRC_ALPHA;
   localparam logic [3:0]  RST_ALPHA_SRC = FAC_ONE;
   localparam logic [3:0]  RST_ALPHA_DST = FAC_INV_SRC_ALPHA;

   localparam logic [7:0]  UNORM_ONE   = 8'd255;
   localparam logic [15:0] ROUND_BIAS  = 16'd127;

   // Exact x / 255 for x below 65280
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

   // x * y + 127, ready for div255
   function automatic logic [15:0] mul_biased(input logic [7:0] x, input logic [7:0] y);
      logic [15:0] p;
      p = {8'd0, x} * {8'd0, y};
      return p + ROUND_BIAS;
   endfunction

   function automatic logic [7:0] factor_sel(
      input logic [3:0] mode,
      input logic [7:0] s,
      input logic [7:0] d,
      input logic [7:0] sa,
      input logic [7:0] da,
      input logic [7:0] da_inv_sa
   );
      logic [7:0] f;
      unique case (mode)
         FAC_ZERO:          f = 8'd0;
         FAC_ONE:           f = UNORM_ONE;
         FAC_SRC:           f = s;
         FAC_INV_SRC:       f = UNORM_ONE - s;
         FAC_DST:           f = d;
         FAC_INV_DST:       f = UNORM_ONE - d;
         FAC_SRC_ALPHA:     f = sa;
         FAC_INV_SRC_ALPHA: f = UNORM_ONE - sa;
         FAC_DST_ALPHA:     f = da;
         FAC_INV_DST_ALPHA: f = UNORM_ONE - da;
         FAC_DA_INV_SA:     f = da_inv_sa;
         default:           f = 8'd0;
      endcase
      return f;
   endfunction

   // Stage bundles between the pipeline modules
   typedef struct packed {
      logic     valid;
      quad_type src;
      quad_type dst;
      quad_type fs;
      quad_type fd;
   } fac_stage_type;

   typedef struct packed {
      logic          valid;
      quad_type      src;
      quad_type      dst;
      quad_wide_type ps_raw;
      quad_wide_type pd_raw;
   } prod_stage_type;

endpackage

@@ src/pbu_factor.sv @@
// ----------------------------------------------------------------------------
// pbu_factor
// Stages 1 and 2: capture the pixel pair with the blended-alpha product,
// then pick source and destination factors for all four lanes.
// ----------------------------------------------------------------------------
module pbu_factor (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  pbu_pkg::req_type      in_pix,
   input  pbu_pkg::cfg_type      cfg,
   output pbu_pkg::fac_stage_type out_stage
);

   logic              s1_valid_ff;
   pbu_pkg::quad_type s1_src_ff, s1_src_in;
   pbu_pkg::quad_type s1_dst_ff, s1_dst_in;
   logic [15:0]       s1_dainv_ff, s1_dainv_in;

   pbu_pkg::fac_stage_type s2_ff, s2_in;

   logic [7:0] da_inv_sa;

   always_comb begin
      s1_src_in   = {in_pix.src_alpha, in_pix.src_blue, in_pix.src_green, in_pix.src_red};
      s1_dst_in   = {in_pix.dst_alpha, in_pix.dst_blue, in_pix.dst_green, in_pix.dst_red};
      s1_dainv_in = pbu_pkg::mul_biased(in_pix.dst_alpha, pbu_pkg::UNORM_ONE - in_pix.src_alpha);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      s1_src_ff   <= s1_src_in;
      s1_dst_ff   <= s1_dst_in;
      s1_dainv_ff <= s1_dainv_in;
   end

   assign da_inv_sa = pbu_pkg::div255(s1_dainv_ff);

   always_comb begin
      s2_in       = '0;
      s2_in.valid = s1_valid_ff;
      s2_in.src   = s1_src_ff;
      s2_in.dst   = s1_dst_ff;
      for (int i = 0; i < 4; i++) begin
         if (i == pbu_pkg::ALPHA_LANE) begin
            s2_in.fs[i] = pbu_pkg::factor_sel(cfg.alpha_src_fac, s1_src_ff[i], s1_dst_ff[i],
               s1_src_ff[pbu_pkg::ALPHA_LANE], s1_dst_ff[pbu_pkg::ALPHA_LANE], da_inv_sa);
            s2_in.fd[i] = pbu_pkg::factor_sel(cfg.alpha_dst_fac, s1_src_ff[i], s1_dst_ff[i],
               s1_src_ff[pbu_pkg::ALPHA_LANE], s1_dst_ff[pbu_pkg::ALPHA_LANE], da_inv_sa);
         end else begin
            s2_in.fs[i] = pbu_pkg::factor_sel(cfg.color_src_fac, s1_src_ff[i], s1_dst_ff[i],
               s1_src_ff[pbu_pkg::ALPHA_LANE], s1_dst_ff[pbu_pkg::ALPHA_LANE], da_inv_sa);
            s2_in.fd[i] = pbu_pkg::factor_sel(cfg.color_dst_fac, s1_src_ff[i], s1_dst_ff[i],
               s1_src_ff[pbu_pkg::ALPHA_LANE], s1_dst_ff[pbu_pkg::ALPHA_LANE], da_inv_sa);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else begin
         s2_ff.valid <= s2_in.valid;
      end
      s2_ff.src <= s2_in.src;
      s2_ff.dst <= s2_in.dst;
      s2_ff.fs  <= s2_in.fs;
      s2_ff.fd  <= s2_in.fd;
   end

   assign out_stage = s2_ff;

endmodule

@@ src/pbu_product.sv @@
// ----------------------------------------------------------------------------
// pbu_product
// Stage 3: multiply each channel by its factor, with rounding bias added.
// ----------------------------------------------------------------------------
module pbu_product (
   input  logic                    clock,
   input  logic                    reset,
   input  pbu_pkg::fac_stage_type  in_stage,
   output pbu_pkg::prod_stage_type out_stage
);

   pbu_pkg::prod_stage_type s3_ff, s3_in;

   always_comb begin
      s3_in       = '0;
      s3_in.valid = in_stage.valid;
      s3_in.src   = in_stage.src;
      s3_in.dst   = in_stage.dst;
      for (int i = 0; i < 4; i++) begin
         s3_in.ps_raw[i] = pbu_pkg::mul_biased(in_stage.src[i], in_stage.fs[i]);
         s3_in.pd_raw[i] = pbu_pkg::mul_biased(in_stage.dst[i], in_stage.fd[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else begin
         s3_ff.valid <= s3_in.valid;
      end
      s3_ff.src    <= s3_in.src;
      s3_ff.dst    <= s3_in.dst;
      s3_ff.ps_raw <= s3_in.ps_raw;
      s3_ff.pd_raw <= s3_in.pd_raw;
   end

   assign out_stage = s3_ff;

endmodule

@@ src/pbu_combine.sv @@
// ----------------------------------------------------------------------------
// pbu_combine
// Stage 4: scale the products back to unorm8 and apply the blend equation
// with saturation; register the result and its strobe.
// ----------------------------------------------------------------------------
module pbu_combine (
   input  logic                    clock,
   input  logic                    reset,
   input  pbu_pkg::prod_stage_type in_stage,
   input  pbu_pkg::cfg_type        cfg,
   output logic                    out_valid,
   output pbu_pkg::rsp_type        out_pix
);

   logic              s4_valid_ff;
   pbu_pkg::quad_type s4_res_ff, s4_res_in;

   always_comb begin
      logic [7:0] ps;
      logic [7:0] pd;
      logic [8:0] sum;
      logic [2:0] eq;
      for (int i = 0; i < 4; i++) begin
         ps  = pbu_pkg::div255(in_stage.ps_raw[i]);
         pd  = pbu_pkg::div255(in_stage.pd_raw[i]);
         sum = {1'b0, ps} + {1'b0, pd};
         eq  = (i == pbu_pkg::ALPHA_LANE) ? cfg.alpha_eq : cfg.color_eq;
         unique case (eq)
            pbu_pkg::EQ_ADD:  s4_res_in[i] = sum[8] ? pbu_pkg::UNORM_ONE : sum[7:0];
            pbu_pkg::EQ_SUB:  s4_res_in[i] = (ps > pd) ? ps - pd : 8'd0;
            pbu_pkg::EQ_RSUB: s4_res_in[i] = (pd > ps) ? pd - ps : 8'd0;
            pbu_pkg::EQ_MIN:  s4_res_in[i] = (in_stage.src[i] < in_stage.dst[i]) ?
                                             in_stage.src[i] : in_stage.dst[i];
            pbu_pkg::EQ_MAX:  s4_res_in[i] = (in_stage.src[i] > in_stage.dst[i]) ?
                                             in_stage.src[i] : in_stage.dst[i];
            default:          s4_res_in[i] = 8'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= in_stage.valid;
      end
      s4_res_ff <= s4_res_in;
   end

   assign out_valid         = s4_valid_ff;
   assign out_pix.out_red   = s4_res_ff[0];
   assign out_pix.out_green = s4_res_ff[1];
   assign out_pix.out_blue  = s4_res_ff[2];
   assign out_pix.out_alpha = s4_res_ff[pbu_pkg::ALPHA_LANE];

endmodule

@@ src/pixel_blend_unit_core.sv @@
// ----------------------------------------------------------------------------
// pixel_blend_unit_core
// Separate RGB / alpha blend-equation unit on unorm8 RGBA pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive req_data (source and destination pixel) and pulse
//   start; the pair is taken at every rising edge with start high and busy
//   low. busy stays low, so a new pair may enter in every cycle.
//   Result channel: rsp_data carries the blended pixel for exactly one cycle
//   with rsp_valid high; the strobe rises once the pair has passed the stage
//   1 to 4 registers, and the result transfers at the edge that samples it.
//   Results leave in input order; one result per input.
//   Throughput is one pixel per clock, set by the four-stage pipeline:
//   alpha product, factor select, channel multiply, rescale and combine.
//   The receiver has no back-pressure: it must take each result when shown.
//   Configuration: APB-style port, registers at byte address 4*index:
//   color equation, alpha equation, then color source/dest factor and alpha
//   source/dest factor. Write only while no pixel is in flight.
//   Reset (synchronous, active high) drops all pixels in flight and loads the
//   default source-over setup.
// ----------------------------------------------------------------------------
module pixel_blend_unit_core (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          start,
   output logic                          busy,
   input  pbu_pkg::req_type              req_data,
   // result channel
   output logic                          rsp_valid,
   output pbu_pkg::rsp_type              rsp_data,
   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pbu_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   pbu_pkg::cfg_type cfg_ff;

   pbu_pkg::fac_stage_type  fac_stage;
   pbu_pkg::prod_stage_type prod_stage;

   logic       csr_wr;
   logic [2:0] csr_index;

   // The pipeline never holds off the source.
   assign busy   = 1'b0;
   assign pready = 1'b1;

   // A write transfer completes in the access phase.
   assign csr_wr    = psel & penable & pwrite & pready;
   assign csr_index = paddr[pbu_pkg::CSR_ADDR_W-1:2];

   // Register file: mask the written value to the register width, drop
   // writes beyond the last register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.color_eq      <= pbu_pkg::RST_COLOR_EQ;
         cfg_ff.alpha_eq      <= pbu_pkg::RST_ALPHA_EQ;
         cfg_ff.color_src_fac <= pbu_pkg::RST_COLOR_SRC;
         cfg_ff.color_dst_fac <= pbu_pkg::RST_COLOR_DST;
         cfg_ff.alpha_src_fac <= pbu_pkg::RST_ALPHA_SRC;
         cfg_ff.alpha_dst_fac <= pbu_pkg::RST_ALPHA_DST;
      end else if (csr_wr) begin
         unique case (csr_index)
            pbu_pkg::REG_COLOR_EQ:  cfg_ff.color_eq      <= pwdata[2:0];
            pbu_pkg::REG_ALPHA_EQ:  cfg_ff.alpha_eq      <= pwdata[2:0];
            pbu_pkg::REG_COLOR_SRC: cfg_ff.color_src_fac <= pwdata[3:0];
            pbu_pkg::REG_COLOR_DST: cfg_ff.color_dst_fac <= pwdata[3:0];
            pbu_pkg::REG_ALPHA_SRC: cfg_ff.alpha_src_fac <= pwdata[3:0];
            pbu_pkg::REG_ALPHA_DST: cfg_ff.alpha_dst_fac <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register, zero above its width.
   always_comb begin
      unique case (csr_index)
         pbu_pkg::REG_COLOR_EQ:  prdata = {29'd0, cfg_ff.color_eq};
         pbu_pkg::REG_ALPHA_EQ:  prdata = {29'd0, cfg_ff.alpha_eq};
         pbu_pkg::REG_COLOR_SRC: prdata = {28'd0, cfg_ff.color_src_fac};
         pbu_pkg::REG_COLOR_DST: prdata = {28'd0, cfg_ff.color_dst_fac};
         pbu_pkg::REG_ALPHA_SRC: prdata = {28'd0, cfg_ff.alpha_src_fac};
         pbu_pkg::REG_ALPHA_DST: prdata = {28'd0, cfg_ff.alpha_dst_fac};
         default:                prdata = 32'd0;
      endcase
   end

   // Stages 1-2: capture pair, form dst alpha * (1 - src alpha), pick factors
   pbu_factor u_factor (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_pix    (req_data),
      .cfg       (cfg_ff),
      .out_stage (fac_stage)
   );

   // Stage 3: channel times factor
   pbu_product u_product (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (fac_stage),
      .out_stage (prod_stage)
   );

   // Stage 4: rescale, apply equation, saturate, present the transfer
   pbu_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (prod_stage),
      .cfg       (cfg_ff),
      .out_valid (rsp_valid),
      .out_pix   (rsp_data)
   );

endmodule

@@ src/pbu_checker.sv @@
// ----------------------------------------------------------------------------
// pbu_checker
// Port-level checks on the blend unit: fixed latency, no spurious results.
// ----------------------------------------------------------------------------
module pbu_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic pready
);

   // Every accepted pair yields a result once it has passed through the pipeline.
   a_latency_fwd : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("accepted pixel produced no result after four cycles");

   // No result without a matching pair accepted earlier.
   a_latency_bwd : assert property (@(posedge clock)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("result strobe without a matching accepted pixel");

   // Reset drops everything in flight.
   a_reset_flush : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_pready : assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("configuration port inserted wait state");

endmodule

bind pixel_blend_unit_core pbu_checker u_pbu_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .pready    (pready)
);

@@ bench/blend_checker.sv @@
// ----------------------------------------------------------------------------
// blend_checker
// Watches the pixel, result and register ports of the blend unit, predicts
// each blended pixel from its own register copy, and compares field by field.
// ----------------------------------------------------------------------------
module blend_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  pbu_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  pbu_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pbu_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   input  logic [31:0]                    prdata,
   input  logic                           pready,
   output int                             mismatch_count,
   output int                             outstanding
);

   pbu_pkg::cfg_type blend_setup;
   pbu_pkg::rsp_type expected_pixels[$];

   // (x * y + 127) / 255 on unorm8
   function automatic logic [7:0] unorm_mul(input logic [7:0] x, input logic [7:0] y);
      int unsigned p;
      p = int'(x) * int'(y) + 127;
      return 8'(p / 255);
   endfunction

   function automatic logic [7:0] blend_factor(
      input logic [3:0] mode,
      input logic [7:0] s,
      input logic [7:0] d,
      input logic [7:0] sa,
      input logic [7:0] da
   );
      case (mode)
         pbu_pkg::FAC_ZERO:          return 8'd0;
         pbu_pkg::FAC_ONE:           return 8'd255;
         pbu_pkg::FAC_SRC:           return s;
         pbu_pkg::FAC_INV_SRC:       return 8'd255 - s;
         pbu_pkg::FAC_DST:           return d;
         pbu_pkg::FAC_INV_DST:       return 8'd255 - d;
         pbu_pkg::FAC_SRC_ALPHA:     return sa;
         pbu_pkg::FAC_INV_SRC_ALPHA: return 8'd255 - sa;
         pbu_pkg::FAC_DST_ALPHA:     return da;
         pbu_pkg::FAC_INV_DST_ALPHA: return 8'd255 - da;
         pbu_pkg::FAC_DA_INV_SA:     return unorm_mul(da, 8'd255 - sa);
         default:                    return 8'd0;
      endcase
   endfunction

   function automatic logic [7:0] blend_lane(
      input logic [2:0] eq,
      input logic [3:0] src_mode,
      input logic [3:0] dst_mode,
      input logic [7:0] s,
      input logic [7:0] d,
      input logic [7:0] sa,
      input logic [7:0] da
   );
      int ps;
      int pd;
      ps = unorm_mul(s, blend_factor(src_mode, s, d, sa, da));
      pd = unorm_mul(d, blend_factor(dst_mode, s, d, sa, da));
      case (eq)
         pbu_pkg::EQ_ADD:  return (ps + pd > 255) ? 8'd255 : 8'(ps + pd);
         pbu_pkg::EQ_SUB:  return (ps > pd) ? 8'(ps - pd) : 8'd0;
         pbu_pkg::EQ_RSUB: return (pd > ps) ? 8'(pd - ps) : 8'd0;
         pbu_pkg::EQ_MIN:  return (s < d) ? s : d;
         pbu_pkg::EQ_MAX:  return (s > d) ? s : d;
         default:          return 8'd0;
      endcase
   endfunction

   function automatic pbu_pkg::rsp_type blend_pixel(input pbu_pkg::req_type px,
                                                    input pbu_pkg::cfg_type c);
      pbu_pkg::rsp_type r;
      r.out_red   = blend_lane(c.color_eq, c.color_src_fac, c.color_dst_fac,
                               px.src_red, px.dst_red, px.src_alpha, px.dst_alpha);
      r.out_green = blend_lane(c.color_eq, c.color_src_fac, c.color_dst_fac,
                               px.src_green, px.dst_green, px.src_alpha, px.dst_alpha);
      r.out_blue  = blend_lane(c.color_eq, c.color_src_fac, c.color_dst_fac,
                               px.src_blue, px.dst_blue, px.src_alpha, px.dst_alpha);
      r.out_alpha = blend_lane(c.alpha_eq, c.alpha_src_fac, c.alpha_dst_fac,
                               px.src_alpha, px.dst_alpha, px.src_alpha, px.dst_alpha);
      return r;
   endfunction

   function automatic logic [31:0] register_value(input logic [2:0] index,
                                                  input pbu_pkg::cfg_type c);
      case (index)
         pbu_pkg::REG_COLOR_EQ:  return 32'(c.color_eq);
         pbu_pkg::REG_ALPHA_EQ:  return 32'(c.alpha_eq);
         pbu_pkg::REG_COLOR_SRC: return 32'(c.color_src_fac);
         pbu_pkg::REG_COLOR_DST: return 32'(c.color_dst_fac);
         pbu_pkg::REG_ALPHA_SRC: return 32'(c.alpha_src_fac);
         default:                return 32'(c.alpha_dst_fac);
      endcase
   endfunction

   task automatic compare_channel(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      pbu_pkg::rsp_type want;
      logic [2:0] index;
      index = paddr[pbu_pkg::CSR_ADDR_W-1:2];
      if (reset) begin
         blend_setup = '{color_eq: pbu_pkg::RST_COLOR_EQ,
                         alpha_eq: pbu_pkg::RST_ALPHA_EQ,
                         color_src_fac: pbu_pkg::RST_COLOR_SRC,
                         color_dst_fac: pbu_pkg::RST_COLOR_DST,
                         alpha_src_fac: pbu_pkg::RST_ALPHA_SRC,
                         alpha_dst_fac: pbu_pkg::RST_ALPHA_DST};
         expected_pixels.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               $error("result with no pixel in flight: %h", rsp_data);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               compare_channel("out_red", want.out_red, rsp_data.out_red);
               compare_channel("out_green", want.out_green, rsp_data.out_green);
               compare_channel("out_blue", want.out_blue, rsp_data.out_blue);
               compare_channel("out_alpha", want.out_alpha, rsp_data.out_alpha);
            end
         end
         if (psel && penable && pready) begin
            if (pwrite) begin
               case (index)
                  pbu_pkg::REG_COLOR_EQ:  blend_setup.color_eq      = pwdata[2:0];
                  pbu_pkg::REG_ALPHA_EQ:  blend_setup.alpha_eq      = pwdata[2:0];
                  pbu_pkg::REG_COLOR_SRC: blend_setup.color_src_fac = pwdata[3:0];
                  pbu_pkg::REG_COLOR_DST: blend_setup.color_dst_fac = pwdata[3:0];
                  pbu_pkg::REG_ALPHA_SRC: blend_setup.alpha_src_fac = pwdata[3:0];
                  pbu_pkg::REG_ALPHA_DST: blend_setup.alpha_dst_fac = pwdata[3:0];
                  default: ;
               endcase
            end else if (index <= pbu_pkg::REG_ALPHA_DST &&
                         prdata !== register_value(index, blend_setup)) begin
               $error("prdata mismatch at register %0d: expected %0d, actual %0d",
                      index, register_value(index, blend_setup), prdata);
               mismatch_count++;
            end
         end
         if (start && !busy)
            expected_pixels.push_back(blend_pixel(req_data, blend_setup));
      end
      outstanding = expected_pixels.size();
   end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives pixel pairs and register setups into the blend unit; the checker
// beside it predicts and compares every blended pixel and register read.
// ----------------------------------------------------------------------------
module tb;

   localparam int TARGET_PIXELS = 1350;
   localparam int CYCLE_LIMIT   = 200000;
   // pipeline depth is four; leave some slack after the last result
   localparam int DRAIN_SLACK   = 8;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           start;
   logic                           busy;
   pbu_pkg::req_type               req_data;
   logic                           rsp_valid;
   pbu_pkg::rsp_type               rsp_data;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [pbu_pkg::CSR_ADDR_W-1:0] paddr;
   logic [31:0]                    pwdata;
   logic [31:0]                    prdata;
   logic                           pready;

   int mismatch_count;
   int outstanding;
   int cycle_count;
   int pixels_sent;

   pixel_blend_unit_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   blend_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always #1 clock = ~clock;

   // All drive tasks start and end at a falling edge.

   // One register transfer: setup cycle, then access until pready.
   task automatic csr_transfer(input logic write, input logic [2:0] index,
                               input logic [31:0] value);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = write;
      paddr   = {index, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // Optionally fill the bits above the register width with noise; the
   // block must mask them off.
   function automatic logic [31:0] pad_value(input logic [3:0] code, input int width,
                                             input bit junk);
      logic [31:0] noise;
      noise = $urandom;
      return junk ? ((noise << width) | 32'(code)) : 32'(code);
   endfunction

   // Write all six registers, then read each back through the checker.
   task automatic apply_setup(input pbu_pkg::cfg_type c, input bit junk);
      csr_transfer(1'b1, pbu_pkg::REG_COLOR_EQ,  pad_value(4'(c.color_eq), 3, junk));
      csr_transfer(1'b1, pbu_pkg::REG_ALPHA_EQ,  pad_value(4'(c.alpha_eq), 3, junk));
      csr_transfer(1'b1, pbu_pkg::REG_COLOR_SRC, pad_value(c.color_src_fac, 4, junk));
      csr_transfer(1'b1, pbu_pkg::REG_COLOR_DST, pad_value(c.color_dst_fac, 4, junk));
      csr_transfer(1'b1, pbu_pkg::REG_ALPHA_SRC, pad_value(c.alpha_src_fac, 4, junk));
      csr_transfer(1'b1, pbu_pkg::REG_ALPHA_DST, pad_value(c.alpha_dst_fac, 4, junk));
      for (int i = pbu_pkg::REG_COLOR_EQ; i <= pbu_pkg::REG_ALPHA_DST; i++)
         csr_transfer(1'b0, 3'(i), 32'd0);
   endtask

   // Offer one pixel pair and hold it until the transfer happens. start
   // stays high so a following call streams back to back.
   task automatic send_pixel(input pbu_pkg::req_type px);
      start    = 1'b1;
      req_data = px;
      do @(posedge clock); while (busy);
      @(negedge clock);
      pixels_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      start = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Hold the sender until every pixel in flight has come back.
   task automatic drain;
      start = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_SLACK) @(negedge clock);
   endtask

   // Bias each channel toward the rails so saturation and rounding corners
   // show up often.
   function automatic pbu_pkg::req_type random_pixel();
      pbu_pkg::req_type px;
      for (int i = 0; i < 8; i++)
         case ($urandom_range(0, 9))
            0:       px[8*i +: 8] = 8'd0;
            1:       px[8*i +: 8] = 8'd255;
            2:       px[8*i +: 8] = 8'd1;
            3:       px[8*i +: 8] = 8'd254;
            default: px[8*i +: 8] = 8'($urandom_range(0, 255));
         endcase
      return px;
   endfunction

   // Mostly legal codes, now and then an unused one.
   function automatic logic [2:0] random_equation();
      if ($urandom_range(0, 7) == 0)
         return 3'($urandom_range(pbu_pkg::EQ_MAX + 1, 7));
      return 3'($urandom_range(pbu_pkg::EQ_ADD, pbu_pkg::EQ_MAX));
   endfunction

   function automatic logic [3:0] random_factor();
      if ($urandom_range(0, 7) == 0)
         return 4'($urandom_range(pbu_pkg::FAC_DA_INV_SA + 1, 15));
      return 4'($urandom_range(pbu_pkg::FAC_ZERO, pbu_pkg::FAC_DA_INV_SA));
   endfunction

   // Stream random pixels, either back to back or in bursts with gaps.
   task automatic run_stream(input int count, input bit bursty);
      int burst_left;
      burst_left = $urandom_range(1, 12);
      repeat (count) begin
         send_pixel(random_pixel());
         burst_left--;
         if (bursty && burst_left == 0) begin
            if ($urandom_range(0, 15) == 0)
               drain();
            else
               pause_sender($urandom_range(1, 8));
            burst_left = $urandom_range(1, 12);
         end
      end
   endtask

   initial begin
      pbu_pkg::cfg_type setup;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      pixels_sent = 0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Check the default source-over setup without writing anything.
      for (int i = pbu_pkg::REG_COLOR_EQ; i <= pbu_pkg::REG_ALPHA_DST; i++)
         csr_transfer(1'b0, 3'(i), 32'd0);
      send_pixel(64'h0000_0000_0000_0000);
      send_pixel(64'hFFFF_FFFF_FFFF_FFFF);
      send_pixel(64'hFFFF_FFFF_0000_0000);
      send_pixel(64'h0000_0000_FFFF_FFFF);
      send_pixel(64'h80C0_4000_2060_A0FF);  // fully transparent source
      send_pixel(64'h1020_30FF_C0B0_A080);  // opaque source
      send_pixel(64'h0180_FE80_FF01_7F80);  // rounding near half
      send_pixel(64'hAA55_AA55_55AA_55AA);

      // Walk every equation code, unused ones too, with unit factors: the
      // pairs make add saturate and sub / min / max pick different sides.
      for (int e = pbu_pkg::EQ_ADD; e < 8; e++) begin
         drain();
         setup = '{color_eq: 3'(e), alpha_eq: 3'(e),
                   color_src_fac: pbu_pkg::FAC_ONE, color_dst_fac: pbu_pkg::FAC_ONE,
                   alpha_src_fac: pbu_pkg::FAC_ONE, alpha_dst_fac: pbu_pkg::FAC_ONE};
         apply_setup(setup, 1'b0);
         send_pixel(64'hC8C8_C8C8_6464_6464);
         send_pixel(64'h6464_6464_C8C8_C8C8);
      end

      // First sweep every code through every register, then random setups.
      for (int phase = 0; pixels_sent < TARGET_PIXELS; phase++) begin
         drain();
         if (phase < 16)
            setup = '{color_eq: 3'(phase), alpha_eq: 3'(phase + 3),
                      color_src_fac: 4'(phase), color_dst_fac: 4'(phase + 5),
                      alpha_src_fac: 4'(phase + 3), alpha_dst_fac: 4'(phase + 9)};
         else
            setup = '{color_eq: random_equation(), alpha_eq: random_equation(),
                      color_src_fac: random_factor(), color_dst_fac: random_factor(),
                      alpha_src_fac: random_factor(), alpha_dst_fac: random_factor()};
         apply_setup(setup, $urandom_range(0, 3) == 0);
         // Addresses past the last register must be ignored.
         if (phase == 16)
            for (int idx = pbu_pkg::REG_ALPHA_DST + 1;
                 idx < 2 ** (pbu_pkg::CSR_ADDR_W - 2); idx++)
               csr_transfer(1'b1, 3'(idx), $urandom);
         run_stream($urandom_range(16, 48), $urandom_range(0, 3) != 0);
      end

      drain();
      if (mismatch_count == 0 && outstanding == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

   // Stop a hung run.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb failed");
      $finish;
   end

endmodule
